// ===== design/akf_pkg.sv =====
package akf_pkg;

  // value format: signed Q16.16
  localparam int W   = 32;
  localparam int F   = 16;
  localparam int DTF = 24;
  localparam int QW  = W + F;

  localparam logic [W-1:0] ONE_Q         = W'(1 << F);
  localparam logic [W-1:0] ALPHA_Q       = W'(((1 << F) + 50) / 100);
  localparam logic [W-1:0] ONE_M_ALPHA_Q = W'((1 << F) - (((1 << F) + 50) / 100));
  localparam logic [W-1:0] QA_RESET      = W'((2 * (1 << F) + 5) / 10);
  localparam logic [W-1:0] QN_RESET      = W'((3 * (1 << F) + 5) / 10);
  localparam logic [W-1:0] P_RESET       = W'(100 * (1 << F));

  localparam logic signed [W-1:0] VAL_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VAL_MIN = {1'b1, {(W-1){1'b0}}};

  // register indexes
  localparam logic [1:0] REG_QA = 2'd0;
  localparam logic [1:0] REG_QB = 2'd1;
  localparam logic [1:0] REG_MR = 2'd2;

  typedef logic signed [W-1:0]     val_t;
  typedef logic signed [W+1:0]     opd_t;
  typedef logic signed [W:0]       mop_t;
  typedef logic signed [2*W+1:0]   prod_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DIV  = 3'b100
  } state_t;

  function automatic opd_t ext(input val_t v);
    ext = {{2{v[W-1]}}, v};
  endfunction

  function automatic mop_t mext(input val_t v);
    mext = {v[W-1], v};
  endfunction

endpackage

// ===== design/angle_kalman_filter_step_core.sv =====
// Two-state Kalman tilt filter (angle, gyro bias) with a complementary-filter
// angle; values are signed Q16.16 with saturation, the time step unsigned Q0.24.
// A new sample is accepted only after the previous result has been loaded into
// the output register. A 28-step sequencer drives one shared 33x33 multiplier
// and one shared saturating adder, and two restoring divisions (one quotient
// bit a cycle) form the Kalman gains, which are zero if the innovation variance
// is not positive. The input is stalled while a sample is in work, including
// while its result waits for the output register to free up. Write the
// registers over the APB port only while no sample is in work.
module angle_kalman_filter_step_core
  import akf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [31:0]   in_measured_angle,
  input  logic signed [31:0]   in_gyro_rate,
  input  logic        [23:0]   in_time_step,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   out_filtered_angle,
  output logic signed [31:0]   out_bias_estimate,
  output logic signed [31:0]   out_blended_angle,
  output logic                 out_saturated,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic        [3:0]    paddr,
  input  logic        [31:0]   pwdata,
  output logic        [31:0]   prdata,
  output logic                 pready
);

  localparam int PW = 2 * W + 3;
  localparam int CW = $clog2(QW);

  localparam logic [4:0] S0 = 5'd0,   S1 = 5'd1,   S2 = 5'd2,   S3 = 5'd3;
  localparam logic [4:0] S4 = 5'd4,   S5 = 5'd5,   S6 = 5'd6,   S7 = 5'd7;
  localparam logic [4:0] S8 = 5'd8,   S9 = 5'd9,   S10 = 5'd10, S11 = 5'd11;
  localparam logic [4:0] S12 = 5'd12, S13 = 5'd13, S14 = 5'd14, S15 = 5'd15;
  localparam logic [4:0] S16 = 5'd16, S17 = 5'd17, S18 = 5'd18, S19 = 5'd19;
  localparam logic [4:0] S20 = 5'd20, S21 = 5'd21, S22 = 5'd22, S23 = 5'd23;
  localparam logic [4:0] S24 = 5'd24, S25 = 5'd25, S26 = 5'd26, S27 = 5'd27;

  // config registers
  logic [W-1:0] qa_r, qb_r, mr_r;

  // filter state
  val_t ang_r, bias_r, comp_r, p0_r, p1_r, p2_r, p3_r;
  val_t ang_nxt, bias_nxt, comp_nxt, p0_nxt, p1_nxt, p2_nxt, p3_nxt;

  // sample and scratch
  val_t          meas_r, gyro_r;
  logic [DTF-1:0] dt_r;
  val_t ta_r, tb_r, ts_r, k0_r, k1_r;
  val_t ta_nxt, tb_nxt, ts_nxt, k0_nxt, k1_nxt;

  // sequencer
  state_t     state_r, state_nxt;
  logic [4:0] step_r, step_nxt;
  logic       sat_r, sat_nxt;

  // divider
  logic [W-1:0]  rem_r, rem_nxt;
  logic [QW-1:0] dvd_r, dvd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          dneg_r, dneg_nxt;

  // output register
  logic out_valid_r, out_valid_nxt;
  val_t out_ang_r, out_bias_r, out_comp_r;
  logic out_sat_r, out_load;

  // shared multiplier
  logic  mul_en, mul_sh24, sh24_r;
  mop_t  mul_a, mul_b;
  prod_t prod_r;

  // shared adder
  logic  add_en, add_sub, use_m;
  opd_t  add_a, add_b;
  logic signed [W+2:0] sum;
  logic  add_ovf;
  val_t  add_res;

  // rounded multiplier result
  logic          mneg, mres_ovf;
  logic [PW-1:0] pmag, rnd, shv, lim;
  val_t          mres;
  opd_t          mres_x;

  logic in_acc, cfg_wr;
  mop_t dt_op;

  assign in_acc = in_valid && !in_stall;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign in_stall = (state_r != ST_IDLE);
  assign dt_op = $signed({{(W+1-DTF){1'b0}}, dt_r});

  // register readback
  always_comb begin
    case (paddr[3:2])
      REG_QA:  prdata = qa_r;
      REG_QB:  prdata = qb_r;
      REG_MR:  prdata = mr_r;
      default: prdata = '0;
    endcase
  end

  // round half away from zero, shift, saturate
  always_comb begin
    mneg = prod_r[2*W+1];
    pmag = mneg ? PW'(-$signed({prod_r[2*W+1], prod_r})) : PW'({1'b0, prod_r});
    rnd  = pmag + (sh24_r ? (PW'(1) << (DTF - 1)) : (PW'(1) << (F - 1)));
    shv  = sh24_r ? (rnd >> DTF) : (rnd >> F);
    lim  = mneg ? (PW'(1) << (W - 1)) : ((PW'(1) << (W - 1)) - PW'(1));
    mres_ovf = (shv > lim);
    if (mres_ovf) begin
      mres = mneg ? VAL_MIN : VAL_MAX;
    end else if (mneg) begin
      mres = -$signed(shv[W-1:0]);
    end else begin
      mres = $signed(shv[W-1:0]);
    end
    mres_x = ext(mres);
  end

  // operand selection per step
  always_comb begin
    add_en = 1'b0; add_sub = 1'b0; use_m = 1'b0;
    add_a = '0; add_b = '0;
    mul_en = 1'b0; mul_sh24 = 1'b0; mul_a = '0; mul_b = '0;
    if (state_r == ST_RUN) begin
      case (step_r)
        S0: begin
          add_en = 1'b1; add_sub = 1'b1; add_a = ext(gyro_r); add_b = ext(bias_r);
        end
        S1: begin
          mul_en = 1'b1; mul_sh24 = 1'b1; mul_a = dt_op; mul_b = mext(ta_r);
        end
        S2: begin
          add_en = 1'b1; use_m = 1'b1; add_a = ext(ang_r); add_b = mres_x;
          mul_en = 1'b1; mul_sh24 = 1'b1; mul_a = dt_op; mul_b = mext(p3_r);
        end
        S3: begin
          add_en = 1'b1; use_m = 1'b1; add_a = mres_x;
        end
        S4: begin
          add_en = 1'b1; add_sub = 1'b1; add_a = ext(tb_r); add_b = ext(p1_r);
        end
        S5: begin
          add_en = 1'b1; add_sub = 1'b1; add_a = ext(ta_r); add_b = ext(p2_r);
        end
        S6: begin
          add_en = 1'b1; add_a = ext(ta_r); add_b = $signed({2'b00, qa_r});
        end
        S7: begin
          mul_en = 1'b1; mul_sh24 = 1'b1; mul_a = dt_op; mul_b = mext(ta_r);
        end
        S8: begin
          add_en = 1'b1; use_m = 1'b1; add_a = ext(p0_r); add_b = mres_x;
        end
        S9: begin
          add_en = 1'b1; add_sub = 1'b1; add_a = ext(p1_r); add_b = ext(tb_r);
          mul_en = 1'b1; mul_sh24 = 1'b1; mul_a = $signed({1'b0, qb_r}); mul_b = dt_op;
        end
        S10: begin
          add_en = 1'b1; add_sub = 1'b1; add_a = ext(p2_r); add_b = ext(tb_r);
        end
        S11: begin
          add_en = 1'b1; use_m = 1'b1; add_a = ext(p3_r); add_b = mres_x;
        end
        S12: begin
          add_en = 1'b1; add_a = ext(p0_r); add_b = $signed({2'b00, mr_r});
        end
        S15: begin
          add_en = 1'b1; add_sub = 1'b1; add_a = ext(meas_r); add_b = ext(ang_r);
        end
        S16: begin
          mul_en = 1'b1; mul_a = mext(k0_r); mul_b = mext(ta_r);
        end
        S17: begin
          add_en = 1'b1; use_m = 1'b1; add_a = ext(ang_r); add_b = mres_x;
          mul_en = 1'b1; mul_a = mext(k1_r); mul_b = mext(ta_r);
        end
        S18: begin
          add_en = 1'b1; use_m = 1'b1; add_a = ext(bias_r); add_b = mres_x;
          mul_en = 1'b1; mul_a = mext(k0_r); mul_b = mext(p0_r);
        end
        S19: begin
          add_en = 1'b1; use_m = 1'b1; add_sub = 1'b1; add_a = ext(p0_r); add_b = mres_x;
          mul_en = 1'b1; mul_a = mext(k0_r); mul_b = mext(p1_r);
        end
        S20: begin
          add_en = 1'b1; use_m = 1'b1; add_sub = 1'b1; add_a = ext(p1_r); add_b = mres_x;
          mul_en = 1'b1; mul_a = mext(k1_r); mul_b = mext(p0_r);
        end
        S21: begin
          add_en = 1'b1; use_m = 1'b1; add_sub = 1'b1; add_a = ext(p2_r); add_b = mres_x;
          mul_en = 1'b1; mul_a = mext(k1_r); mul_b = mext(p1_r);
        end
        S22: begin
          add_en = 1'b1; use_m = 1'b1; add_sub = 1'b1; add_a = ext(p3_r); add_b = mres_x;
        end
        S23: begin
          mul_en = 1'b1; mul_sh24 = 1'b1; mul_a = mext(gyro_r); mul_b = dt_op;
        end
        S24: begin
          add_en = 1'b1; use_m = 1'b1; add_a = ext(comp_r); add_b = mres_x;
        end
        S25: begin
          mul_en = 1'b1; mul_a = $signed({1'b0, ONE_M_ALPHA_Q}); mul_b = mext(ta_r);
        end
        S26: begin
          add_en = 1'b1; use_m = 1'b1; add_a = mres_x;
          mul_en = 1'b1; mul_a = $signed({1'b0, ALPHA_Q}); mul_b = mext(meas_r);
        end
        S27: begin
          add_en = 1'b1; use_m = 1'b1; add_a = ext(tb_r); add_b = mres_x;
        end
        default: begin
        end
      endcase
    end
  end

  // saturating adder
  always_comb begin
    sum = add_sub ? ({add_a[W+1], add_a} - {add_b[W+1], add_b})
                  : ({add_a[W+1], add_a} + {add_b[W+1], add_b});
    add_ovf = !((sum[W+2:W-1] == '0) || (sum[W+2:W-1] == '1));
    add_res = add_ovf ? (sum[W+2] ? VAL_MIN : VAL_MAX) : sum[W-1:0];
  end

  // sequencer and state updates
  always_comb begin
    logic [W:0]    remsh;
    logic          ge;
    logic [QW-1:0] qlim;
    logic          qovf;
    val_t          qval;
    val_t          dsrc;
    logic          fin_ok;

    state_nxt = state_r; step_nxt = step_r;
    ang_nxt = ang_r; bias_nxt = bias_r; comp_nxt = comp_r;
    p0_nxt = p0_r; p1_nxt = p1_r; p2_nxt = p2_r; p3_nxt = p3_r;
    ta_nxt = ta_r; tb_nxt = tb_r; ts_nxt = ts_r; k0_nxt = k0_r; k1_nxt = k1_r;
    rem_nxt = rem_r; dvd_nxt = dvd_r; cnt_nxt = cnt_r; dneg_nxt = dneg_r;
    sat_nxt = sat_r | (add_en & add_ovf) | (use_m & mres_ovf);
    out_load = 1'b0;
    fin_ok = !out_valid_r || !out_stall;
    dsrc = (step_r == S13) ? p0_r : p2_r;

    // one quotient bit per cycle
    remsh = {rem_r, dvd_r[QW-1]};
    ge    = (remsh >= {1'b0, ts_r});
    qlim  = dneg_r ? (QW'(1) << (W - 1)) : ((QW'(1) << (W - 1)) - QW'(1));
    qovf  = ({dvd_r[QW-2:0], ge} > qlim);
    qval  = qovf ? (dneg_r ? VAL_MIN : VAL_MAX)
                 : (dneg_r ? -$signed({dvd_r[W-2:0], ge})
                           : $signed({dvd_r[W-2:0], ge}));

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_RUN;
          step_nxt  = S0;
          sat_nxt   = 1'b0;
        end
      end
      ST_RUN: begin
        step_nxt = step_r + 5'd1;
        case (step_r)
          S0:  ta_nxt = add_res;
          S2:  ang_nxt = add_res;
          S3:  tb_nxt = add_res;
          S4:  ta_nxt = add_res;
          S5:  ta_nxt = add_res;
          S6:  ta_nxt = add_res;
          S8:  p0_nxt = add_res;
          S9:  p1_nxt = add_res;
          S10: p2_nxt = add_res;
          S11: p3_nxt = add_res;
          S12: ts_nxt = add_res;
          S13, S14: begin
            if (!ts_r[W-1] && (ts_r != '0)) begin
              state_nxt = ST_DIV;
              step_nxt  = step_r;
              dneg_nxt  = dsrc[W-1];
              dvd_nxt   = {(dsrc[W-1] ? W'(-dsrc) : W'(dsrc)), {F{1'b0}}};
              rem_nxt   = '0;
              cnt_nxt   = CW'(QW - 1);
            end else begin
              k0_nxt   = '0;
              k1_nxt   = '0;
              sat_nxt  = 1'b1;
              step_nxt = S15;
            end
          end
          S15: ta_nxt = add_res;
          S17: ang_nxt = add_res;
          S18: bias_nxt = add_res;
          S19: ta_nxt = add_res;
          S20: tb_nxt = add_res;
          S21: p2_nxt = add_res;
          S22: begin
            p3_nxt = add_res;
            p0_nxt = ta_r;
            p1_nxt = tb_r;
          end
          S24: ta_nxt = add_res;
          S26: tb_nxt = add_res;
          S27: begin
            if (fin_ok) begin
              comp_nxt  = add_res;
              out_load  = 1'b1;
              state_nxt = ST_IDLE;
            end else begin
              step_nxt = step_r;
              sat_nxt  = sat_r;
            end
          end
          default: begin
          end
        endcase
      end
      ST_DIV: begin
        rem_nxt = ge ? W'(remsh - {1'b0, ts_r}) : remsh[W-1:0];
        dvd_nxt = {dvd_r[QW-2:0], ge};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          sat_nxt   = sat_r | qovf;
          state_nxt = ST_RUN;
          step_nxt  = step_r + 5'd1;
          if (step_r == S13) begin
            k0_nxt = qval;
          end else begin
            k1_nxt = qval;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= S0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
      qa_r        <= QA_RESET;
      qb_r        <= QN_RESET;
      mr_r        <= QN_RESET;
      ang_r       <= '0;
      bias_r      <= '0;
      comp_r      <= '0;
      p0_r        <= P_RESET;
      p1_r        <= '0;
      p2_r        <= '0;
      p3_r        <= P_RESET;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
      ang_r       <= ang_nxt;
      bias_r      <= bias_nxt;
      comp_r      <= comp_nxt;
      p0_r        <= p0_nxt;
      p1_r        <= p1_nxt;
      p2_r        <= p2_nxt;
      p3_r        <= p3_nxt;
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_QA:  qa_r <= pwdata;
          REG_QB:  qb_r <= pwdata;
          REG_MR:  mr_r <= pwdata;
          default: begin
          end
        endcase
      end
    end
  end

  // payload and scratch registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      meas_r <= in_measured_angle;
      gyro_r <= in_gyro_rate;
      dt_r   <= in_time_step;
    end
    ta_r   <= ta_nxt;
    tb_r   <= tb_nxt;
    ts_r   <= ts_nxt;
    k0_r   <= k0_nxt;
    k1_r   <= k1_nxt;
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    cnt_r  <= cnt_nxt;
    dneg_r <= dneg_nxt;
    if (mul_en) begin
      prod_r <= mul_a * mul_b;
      sh24_r <= mul_sh24;
    end
    if (out_load) begin
      out_ang_r  <= ang_r;
      out_bias_r <= bias_r;
      out_comp_r <= add_res;
      out_sat_r  <= sat_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_filtered_angle = out_ang_r;
  assign out_bias_estimate  = out_bias_r;
  assign out_blended_angle  = out_comp_r;
  assign out_saturated      = out_sat_r;

endmodule
